/* rtl/van_leer_limited_face_flux_unit_macros.svh */
// Assertion macros for the van Leer limited face flux unit.
// Included by the top level; depends on nothing else.
`ifndef VAN_LEER_LIMITED_FACE_FLUX_UNIT_MACROS_SVH
`define VAN_LEER_LIMITED_FACE_FLUX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define VLLF_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vllf: assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define VLLF_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vllf: assertion failed");
`else
`define VLLF_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define VLLF_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif
`endif

/* rtl/vllf_pkg.sv */
// Shared types, constants and the face micro-program for the flux unit.
// Used by every module of the block; depends on nothing.
`default_nettype none
package vllf_pkg;

  localparam int QW                = 48;
  localparam int POS_W             = 10;
  localparam int ROW_MAX_CELLS_DEF = 1024;

  typedef logic signed [QW-1:0] q_t;

  localparam q_t Q_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam q_t Q_MIN   = 48'sh8000_0000_0000;
  localparam q_t Q_ONE   = 48'sh0001_0000_0000;
  localparam q_t Q_TWO   = 48'sh0002_0000_0000;
  localparam q_t Q_SIXTH = 48'sd715827882;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_ABS, OP_MIN, OP_FLAG, OP_APPLY, OP_MUL, OP_DIV
  } op_t;

  typedef enum logic [4:0] {
    SRC_T0, SRC_T1, SRC_T2, SRC_T3, SRC_T4, SRC_T5, SRC_T6, SRC_T7,
    SRC_ONE, SRC_TWO, SRC_SIXTH,
    SRC_VF, SRC_VOL_D, SRC_DX_B2, SRC_DX_DIF,
    SRC_RHO_D, SRC_RHO_U, SRC_RHO_W, SRC_E_D, SRC_E_U, SRC_E_W
  } src_t;

  typedef logic [2:0] tmp_t;
  localparam tmp_t T0 = 3'd0;
  localparam tmp_t T1 = 3'd1;
  localparam tmp_t T2 = 3'd2;
  localparam tmp_t T3 = 3'd3;
  localparam tmp_t T4 = 3'd4;
  localparam tmp_t T5 = 3'd5;
  localparam tmp_t T6 = 3'd6;
  localparam tmp_t T7 = 3'd7;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    tmp_t dst;
  } uop_t;

  typedef logic [5:0] pc_t;
  localparam int  PROG_LEN  = 41;
  localparam pc_t PROG_LAST = pc_t'(PROG_LEN - 1);

  typedef struct packed {
    logic              shift;
    logic              latch;
    logic              base;
    logic              issue;
    uop_t              uop;
    logic              load_out;
    logic [POS_W-1:0]  face_pos;
    logic              row_done;
  } ctl_cmd_t;

  typedef struct packed {
    logic arith_done;
    logic arith_busy;
  } dp_stat_t;

  function automatic q_t qsat(logic signed [QW:0] v);
    q_t r;
    if (v[QW] != v[QW-1]) r = v[QW] ? Q_MIN : Q_MAX;
    else r = v[QW-1:0];
    return r;
  endfunction

  function automatic logic [QW-1:0] qmag(q_t v);
    logic [QW-1:0] r;
    r = v[QW-1] ? (~v + 48'd1) : v;
    return r;
  endfunction

  function automatic uop_t mk_uop(op_t o, src_t a, src_t b, tmp_t d);
    uop_t r;
    r.op  = o;
    r.a   = a;
    r.b   = b;
    r.dst = d;
    return r;
  endfunction

  // One face: Courant number, spacing ratio, density limiter, mass flux,
  // mass Courant number, energy limiter, energy flux (mass in T6, energy in T7).
  function automatic uop_t prog_rom(pc_t pc);
    uop_t r;
    case (pc)
      6'd0:  r = mk_uop(OP_DIV,   SRC_VF,    SRC_VOL_D,  T0);
      6'd1:  r = mk_uop(OP_ABS,   SRC_T0,    SRC_T0,     T0);
      6'd2:  r = mk_uop(OP_DIV,   SRC_DX_B2, SRC_DX_DIF, T1);
      6'd3:  r = mk_uop(OP_ADD,   SRC_ONE,   SRC_T0,     T2);
      6'd4:  r = mk_uop(OP_MUL,   SRC_T2,    SRC_T1,     T1);
      6'd5:  r = mk_uop(OP_SUB,   SRC_TWO,   SRC_T0,     T2);
      6'd6:  r = mk_uop(OP_SUB,   SRC_RHO_D, SRC_RHO_U,  T3);
      6'd7:  r = mk_uop(OP_SUB,   SRC_RHO_W, SRC_RHO_D,  T4);
      6'd8:  r = mk_uop(OP_FLAG,  SRC_T3,    SRC_T4,     T0);
      6'd9:  r = mk_uop(OP_ABS,   SRC_T3,    SRC_T3,     T3);
      6'd10: r = mk_uop(OP_ABS,   SRC_T4,    SRC_T4,     T4);
      6'd11: r = mk_uop(OP_MIN,   SRC_T3,    SRC_T4,     T5);
      6'd12: r = mk_uop(OP_MUL,   SRC_T1,    SRC_T3,     T3);
      6'd13: r = mk_uop(OP_MUL,   SRC_T2,    SRC_T4,     T4);
      6'd14: r = mk_uop(OP_ADD,   SRC_T3,    SRC_T4,     T3);
      6'd15: r = mk_uop(OP_MUL,   SRC_SIXTH, SRC_T3,     T3);
      6'd16: r = mk_uop(OP_MIN,   SRC_T5,    SRC_T3,     T5);
      6'd17: r = mk_uop(OP_SUB,   SRC_ONE,   SRC_T0,     T3);
      6'd18: r = mk_uop(OP_MUL,   SRC_T3,    SRC_T5,     T5);
      6'd19: r = mk_uop(OP_APPLY, SRC_T5,    SRC_T5,     T5);
      6'd20: r = mk_uop(OP_ADD,   SRC_RHO_D, SRC_T5,     T5);
      6'd21: r = mk_uop(OP_MUL,   SRC_VF,    SRC_T5,     T6);
      6'd22: r = mk_uop(OP_MUL,   SRC_RHO_D, SRC_VOL_D,  T3);
      6'd23: r = mk_uop(OP_ABS,   SRC_T6,    SRC_T6,     T4);
      6'd24: r = mk_uop(OP_DIV,   SRC_T4,    SRC_T3,     T0);
      6'd25: r = mk_uop(OP_SUB,   SRC_E_D,   SRC_E_U,    T3);
      6'd26: r = mk_uop(OP_SUB,   SRC_E_W,   SRC_E_D,    T4);
      6'd27: r = mk_uop(OP_FLAG,  SRC_T3,    SRC_T4,     T0);
      6'd28: r = mk_uop(OP_ABS,   SRC_T3,    SRC_T3,     T3);
      6'd29: r = mk_uop(OP_ABS,   SRC_T4,    SRC_T4,     T4);
      6'd30: r = mk_uop(OP_MIN,   SRC_T3,    SRC_T4,     T5);
      6'd31: r = mk_uop(OP_MUL,   SRC_T1,    SRC_T3,     T3);
      6'd32: r = mk_uop(OP_MUL,   SRC_T2,    SRC_T4,     T4);
      6'd33: r = mk_uop(OP_ADD,   SRC_T3,    SRC_T4,     T3);
      6'd34: r = mk_uop(OP_MUL,   SRC_SIXTH, SRC_T3,     T3);
      6'd35: r = mk_uop(OP_MIN,   SRC_T5,    SRC_T3,     T5);
      6'd36: r = mk_uop(OP_SUB,   SRC_ONE,   SRC_T0,     T3);
      6'd37: r = mk_uop(OP_MUL,   SRC_T3,    SRC_T5,     T5);
      6'd38: r = mk_uop(OP_APPLY, SRC_T5,    SRC_T5,     T5);
      6'd39: r = mk_uop(OP_ADD,   SRC_E_D,   SRC_T5,     T5);
      6'd40: r = mk_uop(OP_MUL,   SRC_T6,    SRC_T5,     T7);
      default: r = mk_uop(OP_ADD, SRC_T0,    SRC_T0,     T0);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/vllf_arith_unit.sv */
// Multi-cycle saturating Q16.32 multiplier and divider shared by all MUL and DIV steps.
// Depends on vllf_pkg.
`default_nettype none
module vllf_arith_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          is_div,
  input  vllf_pkg::q_t       a,
  input  vllf_pkg::q_t       b,
  output logic               done,
  output logic               busy,
  output vllf_pkg::q_t       result
);

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_DCHK, A_DIV, A_FIN} ast_t;

  ast_t        st_r;
  logic [5:0]  cnt_r;
  logic        neg_r;
  logic        div_r;
  logic        spec_r;
  logic [47:0] spec_mag_r;
  logic [47:0] ma_r, mb_r;
  logic [95:0] acc_r, pp_r;
  logic [47:0] rem_r;
  logic [46:0] q_r, num_r;
  logic        done_r;
  vllf_pkg::q_t result_r;

  logic [23:0] a_part, b_part;
  logic [47:0] prod;
  logic [95:0] pp_sh;
  logic [48:0] trial;
  logic        ge;
  logic [48:0] diff;
  logic [47:0] fin_mag;

  // Partial products of 24-bit halves, shifted into place.
  always_comb begin
    a_part = cnt_r[1] ? ma_r[47:24] : ma_r[23:0];
    b_part = cnt_r[0] ? mb_r[47:24] : mb_r[23:0];
    prod   = a_part * b_part;
    case (cnt_r[1:0])
      2'd0:    pp_sh = {48'd0, prod};
      2'd3:    pp_sh = {prod, 48'd0};
      default: pp_sh = {24'd0, prod, 24'd0};
    endcase
  end

  // One restoring step of the quotient.
  always_comb begin
    trial = {rem_r, num_r[46]};
    diff  = trial - {1'b0, mb_r};
    ge    = (trial >= {1'b0, mb_r});
  end

  always_comb begin
    if (div_r) begin
      fin_mag = spec_r ? spec_mag_r : {1'b0, q_r};
    end else begin
      fin_mag = (|acc_r[95:79]) ? vllf_pkg::Q_MAX : {1'b0, acc_r[78:32]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        A_IDLE: begin
          if (start) begin
            ma_r  <= vllf_pkg::qmag(a);
            mb_r  <= vllf_pkg::qmag(b);
            neg_r <= a[47] ^ b[47];
            div_r <= is_div;
            spec_mag_r <= (a == '0) ? 48'd0 : vllf_pkg::Q_MAX;
            acc_r <= '0;
            pp_r  <= '0;
            q_r   <= '0;
            cnt_r <= 6'd0;
            st_r  <= is_div ? A_DCHK : A_MUL;
          end
        end
        A_MUL: begin
          acc_r <= acc_r + pp_r;
          pp_r  <= pp_sh;
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd4) st_r <= A_FIN;
        end
        A_DCHK: begin
          if (mb_r == '0) begin
            spec_r <= 1'b1;
            st_r   <= A_FIN;
          end else if ({15'd0, ma_r} >= {mb_r, 15'd0}) begin
            spec_r     <= 1'b1;
            spec_mag_r <= vllf_pkg::Q_MAX;
            st_r       <= A_FIN;
          end else begin
            spec_r <= 1'b0;
            rem_r  <= {15'd0, ma_r[47:15]};
            num_r  <= {ma_r[14:0], 32'd0};
            cnt_r  <= 6'd46;
            st_r   <= A_DIV;
          end
        end
        A_DIV: begin
          rem_r <= ge ? diff[47:0] : trial[47:0];
          q_r   <= {q_r[45:0], ge};
          num_r <= {num_r[45:0], 1'b0};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) st_r <= A_FIN;
        end
        A_FIN: begin
          result_r <= neg_r ? (~fin_mag + 48'd1) : fin_mag;
          done_r   <= 1'b1;
          st_r     <= A_IDLE;
        end
        default: st_r <= A_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign busy   = (st_r != A_IDLE);
  assign result = result_r;

endmodule
`default_nettype wire

/* rtl/vllf_datapath.sv */
// Datapath: cell window, face operand registers, temporaries, combinational
// ALU and result register. Depends on vllf_pkg and vllf_arith_unit.
`default_nettype none
module vllf_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  vllf_pkg::q_t                    vol_flux,
  input  vllf_pkg::q_t                    pre_volume,
  input  vllf_pkg::q_t                    density,
  input  vllf_pkg::q_t                    energy,
  input  vllf_pkg::q_t                    vertex_spacing,
  input  vllf_pkg::ctl_cmd_t              cmd,
  output vllf_pkg::dp_stat_t              stat,
  output vllf_pkg::q_t                    mass_flux,
  output vllf_pkg::q_t                    energy_flux,
  output logic [vllf_pkg::POS_W-1:0]      face_position,
  output logic                            row_done
);

  vllf_pkg::q_t win_vf_r[4], win_vol_r[4], win_rho_r[4], win_e_r[4], win_dx_r[4];

  vllf_pkg::q_t vf_r, vol_d_r, dxb_r, dxdif_r;
  vllf_pkg::q_t rho_d_r, rho_u_r, rho_w_r, e_d_r, e_u_r, e_w_r;
  vllf_pkg::q_t t0_r, t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r;
  logic         ok_r, dneg_r;
  vllf_pkg::tmp_t dst_r;

  vllf_pkg::q_t mass_r, ener_r;
  logic [vllf_pkg::POS_W-1:0] pos_r;
  logic         done_r;

  // Face role selection.
  vllf_pkg::q_t vf_sel;
  logic         fwd;
  logic [1:0]   iu, id, iw, idif;

  always_comb begin
    vf_sel = cmd.base ? win_vf_r[3] : win_vf_r[2];
    fwd    = !vf_sel[47] && (vf_sel != '0);
    case ({cmd.base, fwd})
      2'b01:   begin iu = 2'd0; id = 2'd1; iw = 2'd2; idif = 2'd1; end
      2'b00:   begin iu = 2'd3; id = 2'd2; iw = 2'd1; idif = 2'd3; end
      2'b11:   begin iu = 2'd1; id = 2'd2; iw = 2'd3; idif = 2'd2; end
      default: begin iu = 2'd3; id = 2'd3; iw = 2'd2; idif = 2'd3; end
    endcase
  end

  function automatic vllf_pkg::q_t src_mux(
    vllf_pkg::src_t s,
    vllf_pkg::q_t q0, vllf_pkg::q_t q1, vllf_pkg::q_t q2, vllf_pkg::q_t q3,
    vllf_pkg::q_t q4, vllf_pkg::q_t q5, vllf_pkg::q_t q6, vllf_pkg::q_t q7,
    vllf_pkg::q_t vf, vllf_pkg::q_t vd, vllf_pkg::q_t xb, vllf_pkg::q_t xd,
    vllf_pkg::q_t rd, vllf_pkg::q_t ru, vllf_pkg::q_t rw,
    vllf_pkg::q_t ed, vllf_pkg::q_t eu, vllf_pkg::q_t ew);
    vllf_pkg::q_t r;
    case (s)
      vllf_pkg::SRC_T0:     r = q0;
      vllf_pkg::SRC_T1:     r = q1;
      vllf_pkg::SRC_T2:     r = q2;
      vllf_pkg::SRC_T3:     r = q3;
      vllf_pkg::SRC_T4:     r = q4;
      vllf_pkg::SRC_T5:     r = q5;
      vllf_pkg::SRC_T6:     r = q6;
      vllf_pkg::SRC_T7:     r = q7;
      vllf_pkg::SRC_ONE:    r = vllf_pkg::Q_ONE;
      vllf_pkg::SRC_TWO:    r = vllf_pkg::Q_TWO;
      vllf_pkg::SRC_SIXTH:  r = vllf_pkg::Q_SIXTH;
      vllf_pkg::SRC_VF:     r = vf;
      vllf_pkg::SRC_VOL_D:  r = vd;
      vllf_pkg::SRC_DX_B2:  r = xb;
      vllf_pkg::SRC_DX_DIF: r = xd;
      vllf_pkg::SRC_RHO_D:  r = rd;
      vllf_pkg::SRC_RHO_U:  r = ru;
      vllf_pkg::SRC_RHO_W:  r = rw;
      vllf_pkg::SRC_E_D:    r = ed;
      vllf_pkg::SRC_E_U:    r = eu;
      vllf_pkg::SRC_E_W:    r = ew;
      default:              r = '0;
    endcase
    return r;
  endfunction

  vllf_pkg::q_t opa, opb, alu_y, abs_a, wr_val;
  logic [47:0]  mag_a;
  logic         is_multi, wr_en;
  vllf_pkg::tmp_t wr_idx;
  logic         arith_done;
  logic         arith_busy;
  vllf_pkg::q_t arith_res;

  always_comb begin
    opa = src_mux(cmd.uop.a, t0_r, t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r,
                  vf_r, vol_d_r, dxb_r, dxdif_r, rho_d_r, rho_u_r, rho_w_r,
                  e_d_r, e_u_r, e_w_r);
    opb = src_mux(cmd.uop.b, t0_r, t1_r, t2_r, t3_r, t4_r, t5_r, t6_r, t7_r,
                  vf_r, vol_d_r, dxb_r, dxdif_r, rho_d_r, rho_u_r, rho_w_r,
                  e_d_r, e_u_r, e_w_r);
    mag_a = vllf_pkg::qmag(opa);
    abs_a = mag_a[47] ? vllf_pkg::Q_MAX : mag_a;
    case (cmd.uop.op)
      vllf_pkg::OP_ADD: alu_y = vllf_pkg::qsat({opa[47], opa} + {opb[47], opb});
      vllf_pkg::OP_SUB: alu_y = vllf_pkg::qsat({opa[47], opa} - {opb[47], opb});
      vllf_pkg::OP_ABS: alu_y = abs_a;
      vllf_pkg::OP_MIN: alu_y = (opa < opb) ? opa : opb;
      vllf_pkg::OP_APPLY: begin
        if (!ok_r) alu_y = '0;
        else if (dneg_r) alu_y = vllf_pkg::qsat(49'sd0 - {opa[47], opa});
        else alu_y = opa;
      end
      default: alu_y = opa;
    endcase
    is_multi = (cmd.uop.op == vllf_pkg::OP_MUL) || (cmd.uop.op == vllf_pkg::OP_DIV);
    if (arith_done) begin
      wr_en  = 1'b1;
      wr_idx = dst_r;
      wr_val = arith_res;
    end else begin
      wr_en  = cmd.issue && !is_multi && (cmd.uop.op != vllf_pkg::OP_FLAG);
      wr_idx = cmd.uop.dst;
      wr_val = alu_y;
    end
  end

  vllf_arith_unit u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.issue && is_multi),
    .is_div (cmd.uop.op == vllf_pkg::OP_DIV),
    .a      (opa),
    .b      (opb),
    .done   (arith_done),
    .busy   (arith_busy),
    .result (arith_res)
  );

  assign stat = '{arith_done: arith_done, arith_busy: arith_busy};

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_vf_r[i]  <= win_vf_r[i+1];
        win_vol_r[i] <= win_vol_r[i+1];
        win_rho_r[i] <= win_rho_r[i+1];
        win_e_r[i]   <= win_e_r[i+1];
        win_dx_r[i]  <= win_dx_r[i+1];
      end
      win_vf_r[3]  <= vol_flux;
      win_vol_r[3] <= pre_volume;
      win_rho_r[3] <= density;
      win_e_r[3]   <= energy;
      win_dx_r[3]  <= vertex_spacing;
    end
    if (cmd.latch) begin
      vf_r    <= vf_sel;
      vol_d_r <= win_vol_r[id];
      dxb_r   <= cmd.base ? win_dx_r[3] : win_dx_r[2];
      dxdif_r <= win_dx_r[idif];
      rho_d_r <= win_rho_r[id];
      rho_u_r <= win_rho_r[iu];
      rho_w_r <= win_rho_r[iw];
      e_d_r   <= win_e_r[id];
      e_u_r   <= win_e_r[iu];
      e_w_r   <= win_e_r[iw];
    end
    if (cmd.issue && is_multi) dst_r <= cmd.uop.dst;
    if (cmd.issue && (cmd.uop.op == vllf_pkg::OP_FLAG)) begin
      ok_r   <= (opa != '0) && (opb != '0) && (opa[47] == opb[47]);
      dneg_r <= opb[47];
    end
    if (wr_en) begin
      case (wr_idx)
        vllf_pkg::T0: t0_r <= wr_val;
        vllf_pkg::T1: t1_r <= wr_val;
        vllf_pkg::T2: t2_r <= wr_val;
        vllf_pkg::T3: t3_r <= wr_val;
        vllf_pkg::T4: t4_r <= wr_val;
        vllf_pkg::T5: t5_r <= wr_val;
        vllf_pkg::T6: t6_r <= wr_val;
        default:      t7_r <= wr_val;
      endcase
    end
    if (cmd.load_out) begin
      mass_r <= t6_r;
      ener_r <= t7_r;
      pos_r  <= cmd.face_pos;
      done_r <= cmd.row_done;
    end
  end

  assign mass_flux     = mass_r;
  assign energy_flux   = ener_r;
  assign face_position = pos_r;
  assign row_done      = done_r;

endmodule
`default_nettype wire

/* rtl/vllf_ctrl.sv */
// Controller: item handshake, row position, face scheduling and the
// micro-program sequencer. Depends on vllf_pkg.
`default_nettype none
module vllf_ctrl #(
  parameter int ROW_MAX_CELLS = vllf_pkg::ROW_MAX_CELLS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tlast,
  output logic                   in_tready,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output vllf_pkg::ctl_cmd_t     cmd,
  input  vllf_pkg::dp_stat_t     stat
);

  localparam int CNT_W = $clog2(ROW_MAX_CELLS);
  localparam logic [CNT_W-1:0] IDX_LAST = CNT_W'(ROW_MAX_CELLS - 1);

  typedef enum logic [2:0] {S_IDLE, S_LATCH, S_ISSUE, S_WAIT, S_LOAD, S_EMIT} st_t;

  st_t              st_r;
  logic [CNT_W-1:0] cnt_r, idx_r;
  logic             base_r, own_r, out_valid_r;
  vllf_pkg::pc_t    pc_r;

  logic             last, do_norm, do_own, multi;
  logic [CNT_W-1:0] pos_sel;
  logic [CNT_W+vllf_pkg::POS_W-1:0] pos_ext;
  vllf_pkg::uop_t   uop;

  always_comb begin
    last    = in_tlast || (cnt_r == IDX_LAST);
    do_norm = cnt_r >= CNT_W'(3);
    do_own  = last && (cnt_r >= CNT_W'(2));
    uop     = vllf_pkg::prog_rom(pc_r);
    multi   = (uop.op == vllf_pkg::OP_MUL) || (uop.op == vllf_pkg::OP_DIV);
    pos_sel = base_r ? idx_r : (idx_r - CNT_W'(1));
    pos_ext = {{vllf_pkg::POS_W{1'b0}}, pos_sel};

    cmd.shift    = (st_r == S_IDLE) && in_tvalid;
    cmd.latch    = (st_r == S_LATCH);
    cmd.base     = base_r;
    cmd.issue    = (st_r == S_ISSUE);
    cmd.uop      = uop;
    cmd.load_out = (st_r == S_LOAD);
    cmd.face_pos = pos_ext[vllf_pkg::POS_W-1:0];
    cmd.row_done = base_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      base_r      <= 1'b0;
      own_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            idx_r <= cnt_r;
            own_r <= do_own;
            cnt_r <= last ? '0 : cnt_r + CNT_W'(1);
            if (do_norm) begin
              base_r <= 1'b0;
              st_r   <= S_LATCH;
            end else if (do_own) begin
              base_r <= 1'b1;
              st_r   <= S_LATCH;
            end
          end
        end
        S_LATCH: begin
          pc_r <= '0;
          st_r <= S_ISSUE;
        end
        S_ISSUE: begin
          if (multi) st_r <= S_WAIT;
          else if (pc_r == vllf_pkg::PROG_LAST) st_r <= S_LOAD;
          else pc_r <= pc_r + 6'd1;
        end
        S_WAIT: begin
          if (stat.arith_done) begin
            if (pc_r == vllf_pkg::PROG_LAST) begin
              st_r <= S_LOAD;
            end else begin
              pc_r <= pc_r + 6'd1;
              st_r <= S_ISSUE;
            end
          end
        end
        S_LOAD: begin
          out_valid_r <= 1'b1;
          st_r        <= S_EMIT;
        end
        S_EMIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            if (!base_r && own_r) begin
              base_r <= 1'b1;
              st_r   <= S_LATCH;
            end else begin
              st_r <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

/* rtl/van_leer_limited_face_flux_unit.sv */
// Van Leer limited face flux unit: one item per grid cell, up to two face results.
// Each face runs three divisions and twelve multiplies in one shared arithmetic
// unit, plus 26 ALU steps. A new cell is taken only once the faces of the last
// one are out. Reset: rst_n synchronous, active low; clears the controller, row
// counter and output valid; window contents need no reset.
`default_nettype none
`include "van_leer_limited_face_flux_unit_macros.svh"
module van_leer_limited_face_flux_unit #(
  parameter int ROW_MAX_CELLS = vllf_pkg::ROW_MAX_CELLS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input item: one grid cell.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // vol_flux[47:0], pre_volume[95:48], density[143:96], energy[191:144],
  // vertex_spacing[239:192]
  input  wire logic [239:0] in_tdata,
  input  wire logic         in_tlast,   // last_in_row
  // Result item: one face.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // mass_flux[47:0], energy_flux[95:48], face_position[105:96], zero fill above
  output logic [111:0]      out_tdata,
  output logic              out_tlast   // row_done
);

  // The controller accepts a cell, shifts it into the four-cell window and
  // schedules the faces it resolves: the normal face of the cell two back
  // once three cells precede it, then the row's own last face. Each face
  // runs a fixed micro-program in the datapath; the result is held in an
  // output register until taken.

  vllf_pkg::ctl_cmd_t cmd;
  vllf_pkg::dp_stat_t stat;
  vllf_pkg::q_t       mass_flux, energy_flux;
  logic [vllf_pkg::POS_W-1:0] face_position;

  vllf_ctrl #(
    .ROW_MAX_CELLS (ROW_MAX_CELLS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .stat       (stat)
  );

  vllf_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .vol_flux       (in_tdata[47:0]),
    .pre_volume     (in_tdata[95:48]),
    .density        (in_tdata[143:96]),
    .energy         (in_tdata[191:144]),
    .vertex_spacing (in_tdata[239:192]),
    .cmd            (cmd),
    .stat           (stat),
    .mass_flux      (mass_flux),
    .energy_flux    (energy_flux),
    .face_position  (face_position),
    .row_done       (out_tlast)
  );

  assign out_tdata = {6'd0, face_position, energy_flux, mass_flux};

  // A result on offer means no new cell is taken.
  `VLLF_ASSERT_IMP(a_no_accept_while_out, clk, rst_n, out_tvalid, !in_tready)
  // No face completes in the cycle right after a cell is taken.
  `VLLF_ASSERT_NXT(a_no_instant_result, clk, rst_n, in_tvalid && in_tready, !out_tvalid)
  // The arithmetic unit only runs while the controller is inside a face.
  `VLLF_ASSERT_IMP(a_arith_in_face, clk, rst_n, stat.arith_busy, !in_tready && !out_tvalid)

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the van Leer limited face flux unit.
// Predicts every face result in-bench and compares it with the stream out of the block.
// Depends on van_leer_limited_face_flux_unit.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ROW_CELLS = 1024;
  localparam int  WATCHDOG_LIMIT = 20000;
  localparam int  DRAIN_CYCLES = 700;
  localparam longint QMAXL = 64'sh7FFF_FFFF_FFFF;
  localparam longint QMINL = -QMAXL - 1;
  localparam longint ONE_L = 64'sh1_0000_0000;
  localparam longint TWO_L = 64'sh2_0000_0000;
  localparam longint SIXTH_L = 64'sd715827882;

  // One face result as the block reports it.
  typedef struct packed {
    logic [47:0] mass;
    logic [47:0] ener;
    logic [9:0]  pos;
    logic        done;
  } face_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [239:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic         out_tlast;

  // Predictor state: the newest four cells and the row index of the next cell.
  longint cell_rho[4], cell_e[4], cell_vol[4], cell_dx[4], cell_vf[4];
  int     next_index;
  face_t  pending_faces[$];
  int     err_count = 0;
  int     quiet_cycles = 0;
  int     next_gap = 0;  // idle cycles before the next item is offered

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  van_leer_limited_face_flux_unit #(.ROW_MAX_CELLS(ROW_CELLS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  // ---------------- Q16.32 arithmetic, saturating to the 48-bit range ----------------
  function automatic longint q_sat(longint v);
    if (v > QMAXL) return QMAXL;
    if (v < QMINL) return QMINL;
    return v;
  endfunction

  function automatic longint unsigned q_mag(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint q_signed(bit neg, longint unsigned m);
    if (m > QMAXL) m = QMAXL;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint q_abs(longint v);
    return q_signed(1'b0, q_mag(v));
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    p = 128'(q_mag(a)) * 128'(q_mag(b));
    p = p >> 32;
    return q_signed((a < 0) != (b < 0), p > QMAXL ? QMAXL : p[63:0]);
  endfunction

  // The quotient keeps 32 fraction bits, truncated toward zero.
  function automatic longint q_div(longint n, longint d);
    logic [127:0] quo;
    if (d == 0) return n > 0 ? QMAXL : (n < 0 ? -QMAXL : 0);
    quo = (128'(q_mag(n)) << 32) / 128'(q_mag(d));
    return q_signed((n < 0) != (d < 0), quo > QMAXL ? QMAXL : quo[63:0]);
  endfunction

  // A limiter is applied only where both differences share a nonzero sign.
  function automatic longint van_leer_limit(longint upd, longint dnd, longint courant,
                                            longint s3, longint s4);
    longint au, ad, m, t;
    if (upd == 0 || dnd == 0 || ((upd < 0) != (dnd < 0))) return 0;
    au = q_abs(upd);
    ad = q_abs(dnd);
    t = q_mul(SIXTH_L, q_sat(q_mul(s3, au) + q_mul(s4, ad)));
    m = au < ad ? au : ad;
    if (t < m) m = t;
    m = q_mul(q_sat(ONE_L - courant), m);
    return dnd < 0 ? q_sat(-m) : m;
  endfunction

  // Base 0 resolves the face between window slots 1 and 2; base 1 the own face of slot 3.
  function automatic face_t resolve_face(int base, int pos, bit done);
    longint vf, courant, s3, s4, lim, mass, cm, ener;
    int up, dn, dw, ref_dx;
    face_t f;
    vf = cell_vf[base + 2];
    if (vf > 0) begin
      up = base; dn = base + 1; dw = base + 2; ref_dx = dn;
    end else begin
      up = (base + 3 > 3) ? 3 : base + 3; dn = base + 2; dw = base + 1; ref_dx = up;
    end
    courant = q_abs(q_div(vf, cell_vol[dn]));
    s3 = q_mul(q_sat(ONE_L + courant), q_div(cell_dx[base + 2], cell_dx[ref_dx]));
    s4 = q_sat(TWO_L - courant);
    lim = van_leer_limit(q_sat(cell_rho[dn] - cell_rho[up]), q_sat(cell_rho[dw] - cell_rho[dn]),
                         courant, s3, s4);
    mass = q_mul(vf, q_sat(cell_rho[dn] + lim));
    cm = q_div(q_abs(mass), q_mul(cell_rho[dn], cell_vol[dn]));
    lim = van_leer_limit(q_sat(cell_e[dn] - cell_e[up]), q_sat(cell_e[dw] - cell_e[dn]),
                         cm, s3, s4);
    ener = q_mul(mass, q_sat(cell_e[dn] + lim));
    f.mass = mass[47:0];
    f.ener = ener[47:0];
    f.pos = pos[9:0];
    f.done = done;
    return f;
  endfunction

  // Shifts the accepted cell into the window and queues the faces it resolves.
  task automatic predict_faces(logic [239:0] data, logic last_flag);
    int idx;
    bit last;
    idx = next_index;
    last = last_flag || idx >= ROW_CELLS - 1;
    for (int i = 0; i < 3; i++) begin
      cell_vf[i] = cell_vf[i + 1]; cell_vol[i] = cell_vol[i + 1];
      cell_rho[i] = cell_rho[i + 1]; cell_e[i] = cell_e[i + 1]; cell_dx[i] = cell_dx[i + 1];
    end
    cell_vf[3]  = longint'($signed(data[47:0]));
    cell_vol[3] = longint'($signed(data[95:48]));
    cell_rho[3] = longint'($signed(data[143:96]));
    cell_e[3]   = longint'($signed(data[191:144]));
    cell_dx[3]  = longint'($signed(data[239:192]));
    if (idx >= 3) pending_faces.push_back(resolve_face(0, idx - 1, 1'b0));
    if (last && idx >= 2) pending_faces.push_back(resolve_face(1, idx, 1'b1));
    next_index = last ? 0 : idx + 1;
  endtask

  // Sends one cell after the drawn gap and holds it until the block takes it. The gap
  // for the following item is drawn at acceptance so tvalid drops only when it is nonzero.
  task automatic send_cell(logic [47:0] vf, logic [47:0] vol, logic [47:0] rho,
                           logic [47:0] e, logic [47:0] dx, logic last);
    repeat (next_gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {dx, e, rho, vol, vf};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    predict_faces({dx, e, rho, vol, vf}, last);
    next_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (next_gap != 0) in_tvalid <= 1'b0;
  endtask

  // Values mostly near unity so that limiters engage, sometimes anywhere in range.
  function automatic logic [47:0] pick_value(bit keep_positive);
    logic [47:0] v;
    case ($urandom_range(0, 9))
      0: v = 48'({$urandom, $urandom});
      1: v = $urandom_range(0, 3) == 0 ? 48'h0 : ($urandom_range(0, 1) ? 48'h7FFF_FFFF_FFFF
                                                                          : 48'h8000_0000_0000);
      2: v = 48'($urandom_range(0, 1) ? 1 : -1);
      default: v = 48'(longint'($urandom_range(1, 1 << 20)) << 14);
    endcase
    if (keep_positive && v[47]) v = -v;
    if (!keep_positive && $urandom_range(0, 2) == 0) v = -v;
    return v;
  endfunction

  function automatic logic [47:0] pick_flux();
    logic [47:0] v;
    v = 48'(longint'($urandom_range(0, 1 << 18)) << 12);
    if ($urandom_range(0, 1)) v = -v;
    if ($urandom_range(0, 15) == 0) v = 48'({$urandom, $urandom});
    return v;
  endfunction

  task automatic send_random_cell(logic last);
    send_cell(pick_flux(), pick_value($urandom_range(0, 7) != 0),
              pick_value($urandom_range(0, 3) != 0), pick_value(1'b0),
              pick_value($urandom_range(0, 5) != 0), last);
  endtask

  task automatic send_row(int cells);
    for (int i = 0; i < cells; i++) send_random_cell(i == cells - 1);
  endtask

  // ------------------------------- result checking -------------------------------
  always @(posedge clk) begin
    face_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[47:0], out_tdata[95:48], out_tdata[105:96], out_tlast};
      if (pending_faces.size() == 0) begin
        $display("%0t: unexpected face result %h", $realtime, got);
        err_count++;
      end else begin
        want = pending_faces.pop_front();
        if (got.mass !== want.mass) begin
          $display("%0t: mass flux expected %h actual %h", $realtime, want.mass, got.mass);
          err_count++;
        end
        if (got.ener !== want.ener) begin
          $display("%0t: energy flux expected %h actual %h", $realtime, want.ener, got.ener);
          err_count++;
        end
        if (got.pos !== want.pos) begin
          $display("%0t: face position expected %0d actual %0d", $realtime, want.pos, got.pos);
          err_count++;
        end
        if (got.done !== want.done) begin
          $display("%0t: row done expected %b actual %b", $realtime, want.done, got.done);
          err_count++;
        end
        if (out_tdata[111:106] !== '0) begin
          $display("%0t: fill bits expected 0 actual %h", $realtime, out_tdata[111:106]);
          err_count++;
        end
      end
    end
  end

  // The receiver holds tready low for a random count of cycles before each result,
  // with occasional runs where it never stalls.
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Watchdog: a long stretch with no handshake on either side ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------- test tasks ---------------------------------
  // Short rows: a last cell at index 0 or 1 gives nothing, index 2 gives its own face only.
  task automatic test_short_rows();
    send_row(1);
    send_row(2);
    send_row(3);
    send_row(4);
  endtask

  // Extremes of every field, zero divisors, and both flux signs.
  task automatic test_extremes();
    send_cell(48'h7FFF_FFFF_FFFF, 48'h0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0, 1'b0);
    send_cell(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h0, 48'h7FFF_FFFF_FFFF,
              48'h8000_0000_0000, 1'b0);
    send_cell(48'h0, 48'h8000_0000_0000, 48'h8000_0000_0000, 48'h0,
              48'h7FFF_FFFF_FFFF, 1'b0);
    send_cell(48'h0000_4000_0000, 48'h0001_0000_0000, 48'h0001_0000_0000,
              48'h0002_0000_0000, 48'h0001_0000_0000, 1'b0);
    send_cell(48'hFFFF_C000_0000, 48'h0002_0000_0000, 48'h0003_0000_0000,
              48'h0001_0000_0000, 48'h0001_8000_0000, 1'b0);
    send_cell(48'h0000_8000_0000, 48'h0001_0000_0000, 48'h0005_0000_0000,
              48'h0000_0000_0000, 48'h0, 1'b0);
    send_cell(48'hFFFF_FFFF_FFFF, 48'h0, 48'h0, 48'hFFFF_FFFF_FFFF, 48'h1, 1'b1);
  endtask

  // A row with no tlast wraps at the row limit; the block must close it by itself.
  task automatic test_long_row();
    for (int i = 0; i < ROW_CELLS + 3; i++) send_random_cell(1'b0);
    send_random_cell(1'b1);
  endtask

  // Rows of random length with random content.
  task automatic test_random_rows(int total_cells);
    int sent, len;
    sent = 0;
    while (sent < total_cells) begin
      len = $urandom_range(0, 7) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 40);
      send_row(len);
      sent += len;
    end
  endtask

  initial begin
    int drain;
    for (int i = 0; i < 4; i++) begin
      cell_rho[i] = 0; cell_e[i] = 0; cell_vol[i] = 0; cell_dx[i] = 0; cell_vf[i] = 0;
    end
    next_index = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_rows();
    test_extremes();
    test_random_rows(620);
    test_long_row();
    if (next_gap == 0) in_tvalid <= 1'b0;
    drain = 0;
    while (pending_faces.size() != 0) @(posedge clk);
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    if (err_count == 0 && pending_faces.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/vllf_pkg.sv
rtl/vllf_arith_unit.sv
rtl/vllf_datapath.sv
rtl/vllf_ctrl.sv
rtl/van_leer_limited_face_flux_unit.sv
test/tb_top.sv
